// ----- sv/bispectrum_triple_product_core_macros.svh -----
// assertion macros shared by the bispectrum core
`ifndef BISPECTRUM_TRIPLE_PRODUCT_CORE_MACROS_SVH
`define BISPECTRUM_TRIPLE_PRODUCT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BTP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btp assertion failed");

`endif

// ----- sv/btp_pkg.sv -----
`default_nettype none
package btp_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_QUERY     = 2'd1,
        CMD_RANGE_ERR = 2'd2
    } cmd_kind_t;

    // one queued command: a bin write, a query, or a rejected query
    typedef struct packed {
        cmd_kind_t          kind;
        logic [9:0]         idx_a;
        logic [9:0]         idx_b;
        logic [10:0]        idx_c;
        logic signed [15:0] re;
        logic signed [15:0] im;
    } cmd_t;

endpackage
`default_nettype wire

// ----- sv/btp_front.sv -----
`default_nettype none
module btp_front #(
    parameter int unsigned MAX_BINS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [10:0]         cfg_wr_data,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire logic                mode,
    input  wire logic [9:0]          bin_index,
    input  wire logic signed [15:0]  bin_re,
    input  wire logic signed [15:0]  bin_im,
    input  wire logic [9:0]          freq_one,
    input  wire logic [9:0]          freq_two,
    input  wire logic                queue_full,
    output logic                     push,
    output btp_pkg::cmd_t            cmd
);
    import btp_pkg::*;

    localparam int unsigned N_LIMIT = (MAX_BINS > 2047) ? 2047 : MAX_BINS;

    logic [10:0] bins_in_use_reg;
    logic [10:0] bins_in_use_next;
    logic [10:0] n_eff;
    logic [10:0] f_sum;
    logic [10:0] f_wrap;
    logic        range_bad;
    logic        load_ok;

    always_comb
    begin
        bins_in_use_next = cfg_wr_en ? cfg_wr_data : bins_in_use_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= 11'd1024;
        end
        else
        begin
            bins_in_use_reg <= bins_in_use_next;
        end
    end

    // clamp the register to the range the store supports
    always_comb
    begin
        if (bins_in_use_reg < 11'd2)
        begin
            n_eff = 11'd2;
        end
        else if (bins_in_use_reg > 11'(N_LIMIT))
        begin
            n_eff = 11'(N_LIMIT);
        end
        else
        begin
            n_eff = bins_in_use_reg;
        end
    end

    assign f_sum     = {1'b0, freq_one} + {1'b0, freq_two};
    assign f_wrap    = (f_sum >= n_eff) ? (f_sum - n_eff) : f_sum;
    assign range_bad = ({1'b0, freq_one} >= n_eff) || ({1'b0, freq_two} >= n_eff);
    assign load_ok   = {1'b0, bin_index} < n_eff;

    assign item_ready = !queue_full;
    // out-of-range loads are dropped here and never reach the queue
    assign push = item_valid && item_ready && ((mode == MODE_QUERY) || load_ok);

    always_comb
    begin
        cmd.re    = bin_re;
        cmd.im    = bin_im;
        cmd.idx_c = f_wrap;
        if (mode == MODE_LOAD)
        begin
            cmd.kind  = CMD_WRITE;
            cmd.idx_a = bin_index;
            cmd.idx_b = bin_index;
        end
        else
        begin
            cmd.kind  = range_bad ? CMD_RANGE_ERR : CMD_QUERY;
            cmd.idx_a = freq_one;
            cmd.idx_b = freq_two;
        end
    end

endmodule
`default_nettype wire

// ----- sv/btp_fifo.sv -----
`default_nettype none
module btp_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire btp_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output btp_pkg::cmd_t       head_cmd,
    output logic                full,
    output logic                empty
);
    import btp_pkg::*;

    cmd_t                   storage_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign full     = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = storage_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + QUEUE_PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + QUEUE_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- sv/btp_back.sv -----
`default_nettype none
module btp_back #(
    parameter int unsigned MAX_BINS = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire btp_pkg::cmd_t      cmd,
    input  wire logic               queue_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [48:0]      bis_re,
    output logic signed [48:0]      bis_im,
    output logic                    range_error
);
    import btp_pkg::*;

    localparam int unsigned AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    // three copies of the bin store, one per read port of a query
    logic [31:0]        mem_a [MAX_BINS];
    logic [31:0]        mem_b [MAX_BINS];
    logic [31:0]        mem_c [MAX_BINS];

    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      addr_c;
    logic               advance;
    logic               wr_en;
    logic               rd_en;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s1_err_reg, s2_err_reg, s3_err_reg, s4_err_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_err_reg;

    logic [31:0]        a_data_reg, b_data_reg, c_data_reg;
    logic [31:0]        c_s2_reg, c_s3_reg;
    logic signed [15:0] ar, ai, br, bi, cr, ci;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [32:0] pr_reg, pi_reg;
    logic signed [48:0] q_rr_reg, q_ii_reg, q_ir_reg, q_ri_reg;
    logic signed [48:0] bis_re_reg, bis_im_reg;

    // the whole pipe moves as one while the output slot is free or taken
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !queue_empty;
    assign wr_en   = pop && (cmd.kind == CMD_WRITE);
    assign rd_en   = pop && (cmd.kind == CMD_QUERY);

    assign addr_a = AW'(cmd.idx_a);
    assign addr_b = AW'(cmd.idx_b);
    assign addr_c = AW'(cmd.idx_c);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[addr_a] <= {cmd.re, cmd.im};
            mem_b[addr_a] <= {cmd.re, cmd.im};
            mem_c[addr_a] <= {cmd.re, cmd.im};
        end
        if (rd_en)
        begin
            a_data_reg <= mem_a[addr_a];
            b_data_reg <= mem_b[addr_b];
            c_data_reg <= mem_c[addr_c];
        end
    end

    assign ar = a_data_reg[31:16];
    assign ai = a_data_reg[15:0];
    assign br = b_data_reg[31:16];
    assign bi = b_data_reg[15:0];
    assign cr = c_s3_reg[31:16];
    assign ci = c_s3_reg[15:0];

    always_comb
    begin
        out_valid_next = advance ? s4_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_err_reg    <= 1'b0;
            s2_err_reg    <= 1'b0;
            s3_err_reg    <= 1'b0;
            s4_err_reg    <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                s1_valid_reg <= pop && (cmd.kind != CMD_WRITE);
                s1_err_reg   <= cmd.kind == CMD_RANGE_ERR;
                s2_valid_reg <= s1_valid_reg;
                s2_err_reg   <= s1_err_reg;
                s3_valid_reg <= s2_valid_reg;
                s3_err_reg   <= s2_err_reg;
                s4_valid_reg <= s3_valid_reg;
                s4_err_reg   <= s3_err_reg;
                out_err_reg  <= s4_err_reg;
            end
        end
    end

    // X[f1]*X[f2] then times conj(X[f3]), two multiplier ranks, each followed by an adder rank
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_rr_reg   <= ar * br;
            p_ii_reg   <= ai * bi;
            p_ri_reg   <= ar * bi;
            p_ir_reg   <= ai * br;
            c_s2_reg   <= c_data_reg;

            pr_reg     <= 33'(p_rr_reg) - 33'(p_ii_reg);
            pi_reg     <= 33'(p_ri_reg) + 33'(p_ir_reg);
            c_s3_reg   <= c_s2_reg;

            q_rr_reg   <= pr_reg * cr;
            q_ii_reg   <= pi_reg * ci;
            q_ir_reg   <= pi_reg * cr;
            q_ri_reg   <= pr_reg * ci;

            bis_re_reg <= s4_err_reg ? '0 : (q_rr_reg + q_ii_reg);
            bis_im_reg <= s4_err_reg ? '0 : (q_ir_reg - q_ri_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign bis_re      = bis_re_reg;
    assign bis_im      = bis_im_reg;
    assign range_error = out_err_reg;

endmodule
`default_nettype wire

// ----- sv/bispectrum_triple_product_core.sv -----
// Bispectrum triple product: load items (tuser 0) write one Q1.15 complex bin into the bin
// store, query items (tuser 1) return X[f1]*X[f2]*conj(X[(f1+f2) mod N]) exactly, with 45
// fractional bits, or zero with the range flag set when f1 or f2 is at or above N. The front
// classifies each transfer and queues all but out-of-range loads in a four-entry command
// queue; it takes one transfer per clock while the queue has room. The back pops one command
// per clock, while commands wait and the output slot is free or taken, into a pipeline that
// reads three copies of the bin store in parallel and runs two ranks of multipliers; a
// steady one result per clock is kept as long as the output side takes it. Bin writes and
// reads share the queue, so a query always sees every earlier load. No bin is cleared at
// reset: a query of a bin never loaded returns an unspecified value. The user must write
// bins_in_use via cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
`default_nettype none
`include "bispectrum_triple_product_core_macros.svh"
module bispectrum_triple_product_core #(
    parameter int unsigned MAX_BINS = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [10:0]   cfg_wr_data,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // bin_index, bin_re, bin_im, freq_one, freq_two, zero fill
    input  wire logic [63:0]   s_tdata,
    // mode
    input  wire logic [0:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // bis_re, bis_im, zero fill
    output logic [103:0]       m_tdata,
    // range_error
    output logic [0:0]         m_tuser
);
    import btp_pkg::*;

    cmd_t               front_cmd;
    cmd_t               head_cmd;
    logic               fifo_push;
    logic               fifo_pop;
    logic               fifo_full;
    logic               fifo_empty;
    logic signed [48:0] bis_re;
    logic signed [48:0] bis_im;
    logic               range_error;

    btp_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .mode        (s_tuser[0]),
        .bin_index   (s_tdata[9:0]),
        .bin_re      (s_tdata[25:10]),
        .bin_im      (s_tdata[41:26]),
        .freq_one    (s_tdata[51:42]),
        .freq_two    (s_tdata[61:52]),
        .queue_full  (fifo_full),
        .push        (fifo_push),
        .cmd         (front_cmd)
    );

    btp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (front_cmd),
        .pop      (fifo_pop),
        .head_cmd (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    btp_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .queue_empty (fifo_empty),
        .pop         (fifo_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .bis_re      (bis_re),
        .bis_im      (bis_im),
        .range_error (range_error)
    );

    assign m_tdata = {6'b0, bis_im, bis_re};
    assign m_tuser = range_error;

    `BTP_ASSERT_IMPLIES(a_err_result_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    `BTP_ASSERT_IMPLIES(a_no_push_when_full, fifo_push, !fifo_full)
    `BTP_ASSERT_IMPLIES(a_no_pop_when_empty, fifo_pop, !fifo_empty)
    `BTP_ASSERT_NEXT(a_stall_holds_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
`default_nettype wire
